// ===== hw/rtl/bcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, limits and BCD helper functions for the BCD calendar clock.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Field stepped by an adjust word
  typedef enum logic [2:0] {
    FLD_SEC     = 3'd0,
    FLD_MIN     = 3'd1,
    FLD_HOUR    = 3'd2,
    FLD_WDAY    = 3'd3,
    FLD_DAY     = 3'd4,
    FLD_MONTH   = 3'd5,
    FLD_YEAR    = 3'd6,
    FLD_INVALID = 3'd7
  } field_t;

  // Full time and date register set
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [2:0] wday;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
  } cal_t;

  // Upper limits, compared as raw 8-bit values
  localparam logic [7:0] SEC_MAX   = 8'h59;
  localparam logic [7:0] HOUR_MAX  = 8'h23;
  localparam logic [7:0] WDAY_MAX  = 8'h07;
  localparam logic [7:0] DAY_MAX   = 8'h31;
  localparam logic [7:0] MONTH_MAX = 8'h12;
  localparam logic [7:0] YEAR_MAX  = 8'h99;

  localparam logic [7:0] ZERO_MIN = 8'h00;
  localparam logic [7:0] ONE_MIN  = 8'h01;

  localparam cal_t CAL_RESET = '{sec: 7'h00, min: 7'h00, hour: 6'h00, wday: 3'd1,
                                 day: 6'h01, month: 5'h01, year: 8'h00};

  // Add one, then fix the low digit if it went past nine
  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] > 4'd9) r = r + 8'd6;
    return r;
  endfunction

  // Tens digit times ten plus units digit (no check on digit range)
  function automatic logic [7:0] bcd_bin(input logic [7:0] v);
    return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
  endfunction

  // Increment and wrap to the minimum past the maximum
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [7:0] r;
    r = bcd_inc(v);
    return (r > hi) ? lo : r;
  endfunction

  // Month length from a binary month; out-of-range months count as 31 days
  function automatic logic [4:0] days_in(input logic [7:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      8'd2:                      d = leap ? 5'd29 : 5'd28;
      8'd4, 8'd6, 8'd9, 8'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/bcdc_tick.sv =====
// ----------------------------------------------------------------------------
// bcdc_tick
// One-second advance of the time and date with carry from field to field.
// ----------------------------------------------------------------------------
module bcdc_tick (
  input  bcdc_pkg::cal_t cur,
  output bcdc_pkg::cal_t nxt
);
  import bcdc_pkg::*;

  logic [7:0] s_inc, m_inc, h_inc, d_inc, mo_inc, y_inc;
  logic       s_wrap, m_wrap, h_wrap, d_wrap, mo_wrap, y_wrap;
  logic       c_min, c_hour, c_day, c_month, c_year;
  logic       leap;
  logic [4:0] mlen;

  // Per-field increment and wrap detect
  always_comb begin
    s_inc  = bcd_inc({1'b0, cur.sec});
    m_inc  = bcd_inc({1'b0, cur.min});
    h_inc  = bcd_inc({2'b00, cur.hour});
    d_inc  = bcd_inc({2'b00, cur.day});
    mo_inc = bcd_inc({3'b000, cur.month});
    y_inc  = bcd_inc(cur.year);

    s_wrap  = s_inc > SEC_MAX;
    m_wrap  = m_inc > SEC_MAX;
    h_wrap  = h_inc > HOUR_MAX;
    mo_wrap = mo_inc > MONTH_MAX;
    y_wrap  = y_inc > YEAR_MAX;

    // leap when binary year mod 4 is zero; month length from the old month
    leap   = (bcd_bin(cur.year) & 8'd3) == 8'd0;
    mlen   = days_in(bcd_bin({3'b000, cur.month}), leap);
    d_wrap = bcd_bin(d_inc) > {3'b000, mlen};
  end

  // Carry chain
  assign c_min   = s_wrap;
  assign c_hour  = c_min && m_wrap;
  assign c_day   = c_hour && h_wrap;
  assign c_month = c_day && d_wrap;
  assign c_year  = c_month && mo_wrap;

  always_comb begin
    nxt = cur;
    nxt.sec = s_wrap ? 7'h00 : s_inc[6:0];
    if (c_min)   nxt.min   = m_wrap ? 7'h00 : m_inc[6:0];
    if (c_hour)  nxt.hour  = h_wrap ? 6'h00 : h_inc[5:0];
    if (c_day) begin
      nxt.wday = (cur.wday == 3'd7) ? 3'd1 : cur.wday + 3'd1;
      nxt.day  = d_wrap ? 6'h01 : d_inc[5:0];
    end
    if (c_month) nxt.month = mo_wrap ? 5'h01 : mo_inc[4:0];
    if (c_year)  nxt.year  = y_wrap ? 8'h00 : y_inc;
  end

endmodule

// ===== hw/rtl/bcdc_update.sv =====
// ----------------------------------------------------------------------------
// bcdc_update
// Next-state logic for one item: tick, adjust write, load or no-op.
// ----------------------------------------------------------------------------
module bcdc_update (
  input  bcdc_pkg::mode_t  mode,
  input  bcdc_pkg::cal_t   load,
  input  bcdc_pkg::cal_t   cur,
  input  logic             skip,
  input  bcdc_pkg::field_t field,
  output bcdc_pkg::cal_t   nxt,
  output logic             skip_next,
  output logic             ignored,
  output logic             ferr
);
  import bcdc_pkg::*;

  cal_t       ticked;
  logic [7:0] st_sec, st_min, st_hour, st_wday, st_day, st_month, st_year;

  bcdc_tick u_tick (
    .cur (cur),
    .nxt (ticked)
  );

  // Adjust candidates for every field
  always_comb begin
    st_sec   = bcd_step({1'b0, cur.sec}, ZERO_MIN, SEC_MAX);
    st_min   = bcd_step({1'b0, cur.min}, ZERO_MIN, SEC_MAX);
    st_hour  = bcd_step({2'b00, cur.hour}, ZERO_MIN, HOUR_MAX);
    st_wday  = bcd_step({5'b00000, cur.wday}, ONE_MIN, WDAY_MAX);
    st_day   = bcd_step({2'b00, cur.day}, ONE_MIN, DAY_MAX);
    st_month = bcd_step({3'b000, cur.month}, ONE_MIN, MONTH_MAX);
    st_year  = bcd_step(cur.year, ZERO_MIN, YEAR_MAX);
  end

  // Item select
  always_comb begin
    nxt       = cur;
    skip_next = skip;
    ignored   = 1'b0;
    ferr      = 1'b0;
    unique case (mode)
      MODE_TICK: nxt = ticked;
      MODE_ADJUST: begin
        if (skip) begin
          // alternation: this write only clears the skip flag
          skip_next = 1'b0;
          ignored   = 1'b1;
        end else begin
          skip_next = 1'b1;
          unique case (field)
            FLD_SEC:     nxt.sec   = st_sec[6:0];
            FLD_MIN:     nxt.min   = st_min[6:0];
            FLD_HOUR:    nxt.hour  = st_hour[5:0];
            FLD_WDAY:    nxt.wday  = st_wday[2:0];
            FLD_DAY:     nxt.day   = st_day[5:0];
            FLD_MONTH:   nxt.month = st_month[4:0];
            FLD_YEAR:    nxt.year  = st_year;
            FLD_INVALID: begin
              ferr      = 1'b1;
              skip_next = 1'b0;
            end
          endcase
        end
      end
      MODE_LOAD: nxt = load;
      MODE_NOP:  nxt = cur;
    endcase
  end

endmodule

// ===== hw/rtl/bcd_calendar_clock.sv =====
// ----------------------------------------------------------------------------
// bcd_calendar_clock
// BCD time-of-day and calendar register set with tick, adjust and load items.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while in_stall is low. Its result word passes
// through the input register, then one pass through the update logic into the
// state and result registers. The state update is a single combinational pass
// from the current register set, so consecutive items run back to back. A
// stalled result holds the input register, and the input stalls while the
// input register holds an item and the result register is full and stalled.
// The adjust field register is written through the cfg port, which is always
// ready; write it only while no items are in flight.
module bcd_calendar_clock (
  input  logic       clk,
  input  logic       rst,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [6:0] load_seconds,
  input  logic [6:0] load_minutes,
  input  logic [5:0] load_hours,
  input  logic [2:0] load_weekday,
  input  logic [5:0] load_day,
  input  logic [4:0] load_month,
  input  logic [7:0] load_year,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] seconds,
  output logic [6:0] minutes,
  output logic [5:0] hours,
  output logic [2:0] weekday,
  output logic [5:0] day,
  output logic [4:0] month,
  output logic [7:0] year,
  output logic       adjust_ignored,
  output logic       field_error
);
  import bcdc_pkg::*;

  field_t adjust_field;

  logic   s1_valid;
  mode_t  s1_mode;
  cal_t   s1_load;

  cal_t   cal;
  logic   skip;

  cal_t   cal_next;
  logic   skip_next;
  logic   ignored_next, ferr_next;

  cal_t   res;
  logic   res_ignored, res_ferr;

  logic   out_free, advance, in_take;

  // Pipeline flow control
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_field <= FLD_SEC;
    end else if (cfg_valid && cfg_ready) begin
      adjust_field <= field_t'(cfg_data);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode <= mode_t'(mode);
      s1_load <= '{sec: load_seconds, min: load_minutes, hour: load_hours,
                   wday: load_weekday, day: load_day, month: load_month,
                   year: load_year};
    end
  end

  bcdc_update u_update (
    .mode      (s1_mode),
    .load      (s1_load),
    .cur       (cal),
    .skip      (skip),
    .field     (adjust_field),
    .nxt       (cal_next),
    .skip_next (skip_next),
    .ignored   (ignored_next),
    .ferr      (ferr_next)
  );

  // Clock and calendar state
  always_ff @(posedge clk) begin
    if (rst) begin
      cal  <= CAL_RESET;
      skip <= 1'b0;
    end else if (advance) begin
      cal  <= cal_next;
      skip <= skip_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res         <= cal_next;
      res_ignored <= ignored_next;
      res_ferr    <= ferr_next;
    end
  end

  assign seconds        = res.sec;
  assign minutes        = res.min;
  assign hours          = res.hour;
  assign weekday        = res.wday;
  assign day            = res.day;
  assign month          = res.month;
  assign year           = res.year;
  assign adjust_ignored = res_ignored;
  assign field_error    = res_ferr;

endmodule

// ===== hw/rtl/bcdc_checker.sv =====
// ----------------------------------------------------------------------------
// bcdc_checker
// Port-level checks for the BCD calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
module bcdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] seconds,
  input logic [6:0] minutes,
  input logic [5:0] hours,
  input logic [2:0] weekday,
  input logic [5:0] day,
  input logic [4:0] month,
  input logic [7:0] year,
  input logic       adjust_ignored,
  input logic       field_error
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a full, stalled result register
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  // A skipped adjust never also reports a field error
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(adjust_ignored && field_error))
    else $error("both adjust flags set");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(seconds) && $stable(minutes)
      && $stable(hours) && $stable(weekday) && $stable(day) && $stable(month)
      && $stable(year) && $stable(adjust_ignored) && $stable(field_error)))
    else $error("stalled result changed");

endmodule

bind bcd_calendar_clock bcdc_checker u_bcdc_checker (.*);

// ===== dv/tb_bcd_calendar_clock.sv =====
// ----------------------------------------------------------------------------
// tb_bcd_calendar_clock
// Self-checking bench for the BCD calendar clock. A local calendar model
// predicts the full register set and both flags for every accepted word and
// the result stream is compared in order. Directed words hit the rollovers,
// leap days, odd months, out-of-range loads, the adjust alternation and the
// invalid field select. Random phases then sweep every adjust field setting
// under random sender gaps, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_bcd_calendar_clock;
  timeunit 1ns;
  timeprecision 1ps;

  import bcdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // One predicted result word
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [2:0] wday;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic       ignored;
    logic       ferr;
  } clock_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [6:0] load_seconds;
  logic [6:0] load_minutes;
  logic [5:0] load_hours;
  logic [2:0] load_weekday;
  logic [5:0] load_day;
  logic [4:0] load_month;
  logic [7:0] load_year;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] seconds;
  logic [6:0] minutes;
  logic [5:0] hours;
  logic [2:0] weekday;
  logic [5:0] day;
  logic [4:0] month;
  logic [7:0] year;
  logic       adjust_ignored;
  logic       field_error;

  // Calendar model state, kept at 8 bits like the block's compare logic
  logic [7:0] cur_sec, cur_min, cur_hour, cur_wday, cur_day, cur_month, cur_year;
  logic       skip_adjust;
  field_t     adj_sel;

  clock_word_t predicted_clock_q[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;
  int unsigned hold_cycles = 0;
  int unsigned n_tick = 0, n_adjust = 0, n_load = 0, n_nop = 0;
  int unsigned n_checked = 0, n_skipped = 0, n_ferr = 0;

  bcd_calendar_clock DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .load_seconds  (load_seconds),
    .load_minutes  (load_minutes),
    .load_hours    (load_hours),
    .load_weekday  (load_weekday),
    .load_day      (load_day),
    .load_month    (load_month),
    .load_year     (load_year),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .seconds       (seconds),
    .minutes       (minutes),
    .hours         (hours),
    .weekday       (weekday),
    .day           (day),
    .month         (month),
    .year          (year),
    .adjust_ignored(adjust_ignored),
    .field_error   (field_error)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] bcd_next(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    return (r[3:0] > 4'd9) ? r + 8'd6 : r;
  endfunction

  // Digits read as decimal, no digit range check
  function automatic int unsigned bcd_value(input logic [7:0] v);
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned n);
    logic [7:0] r;
    r[7:4] = 4'(n / 10);
    r[3:0] = 4'(n % 10);
    return r;
  endfunction

  // Out-of-range months count as 31 days
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:           return (y % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic logic [7:0] step_wrap(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] r;
    r = bcd_next(v);
    return (r > hi) ? lo : r;
  endfunction

  function automatic void reset_calendar();
    cur_sec     = 8'h00;
    cur_min     = 8'h00;
    cur_hour    = 8'h00;
    cur_wday    = 8'd1;
    cur_day     = 8'h01;
    cur_month   = 8'h01;
    cur_year    = 8'h00;
    skip_adjust = 1'b0;
    adj_sel     = FLD_SEC;
  endfunction

  // One second with carry through the whole date
  function automatic void tick_second();
    cur_sec = bcd_next(cur_sec);
    if (cur_sec <= SEC_MAX) return;
    cur_sec = 8'h00;
    cur_min = bcd_next(cur_min);
    if (cur_min <= SEC_MAX) return;
    cur_min = 8'h00;
    cur_hour = bcd_next(cur_hour);
    if (cur_hour <= HOUR_MAX) return;
    cur_hour = 8'h00;
    cur_wday = (cur_wday % 8'd7) + 8'd1;
    cur_day = bcd_next(cur_day);
    if (bcd_value(cur_day) <= month_days(bcd_value(cur_month), bcd_value(cur_year)))
      return;
    cur_day = 8'h01;
    cur_month = bcd_next(cur_month);
    if (cur_month <= MONTH_MAX) return;
    cur_month = 8'h01;
    cur_year = bcd_next(cur_year);
    if (cur_year > YEAR_MAX) cur_year = 8'h00;
  endfunction

  // Apply one word to the model and return the word the block should produce
  function automatic clock_word_t advance_clock(input mode_t m, input cal_t ld);
    clock_word_t w;
    w.ignored = 1'b0;
    w.ferr    = 1'b0;
    case (m)
      MODE_TICK: tick_second();
      MODE_ADJUST: begin
        if (skip_adjust) begin
          skip_adjust = 1'b0;
          w.ignored   = 1'b1;
        end else begin
          case (adj_sel)
            FLD_SEC:     cur_sec   = step_wrap(cur_sec, ZERO_MIN, SEC_MAX);
            FLD_MIN:     cur_min   = step_wrap(cur_min, ZERO_MIN, SEC_MAX);
            FLD_HOUR:    cur_hour  = step_wrap(cur_hour, ZERO_MIN, HOUR_MAX);
            FLD_WDAY:    cur_wday  = step_wrap(cur_wday, ONE_MIN, WDAY_MAX);
            FLD_DAY:     cur_day   = step_wrap(cur_day, ONE_MIN, DAY_MAX);
            FLD_MONTH:   cur_month = step_wrap(cur_month, ONE_MIN, MONTH_MAX);
            FLD_YEAR:    cur_year  = step_wrap(cur_year, ZERO_MIN, YEAR_MAX);
            FLD_INVALID: w.ferr    = 1'b1;
            default:     w.ferr    = 1'b1;
          endcase
          if (!w.ferr) skip_adjust = 1'b1;
        end
      end
      MODE_LOAD: begin
        cur_sec   = {1'b0, ld.sec};
        cur_min   = {1'b0, ld.min};
        cur_hour  = {2'b00, ld.hour};
        cur_wday  = {5'b00000, ld.wday};
        cur_day   = {2'b00, ld.day};
        cur_month = {3'b000, ld.month};
        cur_year  = ld.year;
      end
      default: ;
    endcase
    w.sec   = cur_sec[6:0];
    w.min   = cur_min[6:0];
    w.hour  = cur_hour[5:0];
    w.wday  = cur_wday[2:0];
    w.day   = cur_day[5:0];
    w.month = cur_month[4:0];
    w.year  = cur_year;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Load value builders
  // ---------------------------------------------------------------------------

  function automatic cal_t make_cal(input logic [7:0] s, input logic [7:0] mi,
                                    input logic [7:0] h, input logic [7:0] wd,
                                    input logic [7:0] d, input logic [7:0] mo,
                                    input logic [7:0] y);
    cal_t c;
    c.sec   = s[6:0];
    c.min   = mi[6:0];
    c.hour  = h[5:0];
    c.wday  = wd[2:0];
    c.day   = d[5:0];
    c.month = mo[4:0];
    c.year  = y;
    return c;
  endfunction

  // Every bit random; also used as don't-care payload for ticks and adjusts
  function automatic cal_t noise_cal();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return cal_t'(bits[$bits(cal_t)-1:0]);
  endfunction

  // Valid date a few seconds short of a minute, hour, day, month or year carry
  function automatic cal_t near_rollover();
    cal_t c;
    int unsigned mon, yr, len;
    mon     = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
    yr      = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
    len     = month_days(mon, yr);
    c.sec   = 7'(to_bcd($urandom_range(50, 59)));
    c.min   = ($urandom_range(0, 3) != 0) ? 7'h59 : 7'(to_bcd($urandom_range(0, 59)));
    c.hour  = ($urandom_range(0, 2) != 0) ? 6'h23 : 6'(to_bcd($urandom_range(0, 23)));
    c.wday  = 3'($urandom_range(1, 7));
    c.day   = 6'(to_bcd(($urandom_range(0, 2) != 0) ? len : $urandom_range(1, len)));
    c.month = 5'(to_bcd(mon));
    c.year  = to_bcd(yr);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one word; bursts of random length separated by random gaps
  task automatic send_word(input mode_t m, input cal_t ld);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left   = burst_left - 1;
    in_valid     <= 1'b1;
    mode         <= m;
    load_seconds <= ld.sec;
    load_minutes <= ld.min;
    load_hours   <= ld.hour;
    load_weekday <= ld.wday;
    load_day     <= ld.day;
    load_month   <= ld.month;
    load_year    <= ld.year;
    do @(posedge clk); while (in_stall);
    predicted_clock_q.push_back(advance_clock(m, ld));
    case (m)
      MODE_TICK:   n_tick++;
      MODE_ADJUST: n_adjust++;
      MODE_LOAD:   n_load++;
      default:     n_nop++;
    endcase
  endtask

  // Sender idles until every predicted word has come back, plus pipeline slack
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (predicted_clock_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_adjust_field(input field_t f);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    adj_sel   = f;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle code right after reset shows the reset register set
  task automatic test_reset_values();
    send_word(MODE_NOP, noise_cal());
  endtask

  // Full carry from the last second of a year, weekday 7 wraps to 1
  task automatic test_year_rollover();
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd7, 8'h31, 8'h12, 8'h99));
    send_word(MODE_TICK, noise_cal());
  endtask

  // February in leap and common years; year 0x10 reads as ten, not leap
  task automatic test_february();
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd3, 8'h28, 8'h02, 8'h24));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd4, 8'h29, 8'h02, 8'h24));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd5, 8'h28, 8'h02, 8'h23));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd6, 8'h28, 8'h02, 8'h10));
    send_word(MODE_TICK, noise_cal());
  endtask

  // 30-day month, month zero and an out-of-range month treated as 31 days
  task automatic test_odd_months();
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd2, 8'h30, 8'h04, 8'h05));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd2, 8'h30, 8'h00, 8'h05));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h59, 8'h59, 8'h23, 8'd2, 8'h31, 8'h15, 8'h05));
    send_word(MODE_TICK, noise_cal());
  endtask

  // Loads take any bit pattern unchecked; tick from all ones and all zeros
  task automatic test_load_extremes();
    send_word(MODE_LOAD, make_cal(8'h7F, 8'h7F, 8'h3F, 8'd7, 8'h3F, 8'h1F, 8'hFF));
    send_word(MODE_TICK, noise_cal());
    send_word(MODE_LOAD, make_cal(8'h00, 8'h00, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00));
    send_word(MODE_TICK, noise_cal());
  endtask

  // Invalid field select flags an error and does not arm the skip
  task automatic test_invalid_field();
    wait_drained();
    set_adjust_field(FLD_INVALID);
    send_word(MODE_ADJUST, noise_cal());
    send_word(MODE_ADJUST, noise_cal());
  endtask

  // Weekday wraps 7 -> 1, the following adjust is skipped
  task automatic test_adjust_alternation();
    wait_drained();
    set_adjust_field(FLD_WDAY);
    send_word(MODE_LOAD, make_cal(8'h12, 8'h34, 8'h05, 8'd7, 8'h15, 8'h06, 8'h42));
    send_word(MODE_ADJUST, noise_cal());
    send_word(MODE_ADJUST, noise_cal());
  endtask

  // Loads near a carry followed by ticks, plus adjust runs, tick runs and noise
  task automatic run_random_phase(input int unsigned quota);
    int unsigned sent, pick, n;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_word(MODE_LOAD, near_rollover());
        n = $urandom_range(1, 12);
        repeat (n) send_word(MODE_TICK, noise_cal());
        sent += n + 1;
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) != 0) begin
          send_word(MODE_LOAD, near_rollover());
          sent++;
        end
        n = $urandom_range(1, 4);
        repeat (n) send_word(MODE_ADJUST, noise_cal());
        sent += n;
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) send_word(MODE_TICK, noise_cal());
        sent += n;
      end else if (pick < 93) begin
        send_word(MODE_LOAD, noise_cal());
        sent++;
      end else begin
        send_word(MODE_NOP, noise_cal());
        sent++;
      end
    end
  endtask

  // Sixteen phases; every eight consecutive ones cover all field selects
  task automatic test_random_phases();
    int unsigned offset;
    field_t sel;
    offset = $urandom_range(0, 7);
    for (int p = 0; p < 16; p++) begin
      wait_drained();
      sel = field_t'((p * 5 + offset) % 8);
      set_adjust_field(sel);
      gap_max   = (p == 0) ? 0 : $urandom_range(0, 6);
      stall_pct = (p == 0) ? 0 : $urandom_range(0, 3) * 20;
      run_random_phase(38);
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_receiver_hold();
    wait_drained();
    gap_max     = 0;
    stall_pct   = 0;
    hold_cycles = 80;
    send_word(MODE_LOAD, near_rollover());
    repeat (31) send_word(MODE_TICK, noise_cal());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: runs of random length, stall odds set per phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles = hold_cycles - 1;
      stall_run   = 0;
    end else if (stall_run != 0) begin
      stall_run = stall_run - 1;
    end else begin
      stall_run = $urandom_range(0, 11);
      out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    clock_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_clock_q.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        want = predicted_clock_q.pop_front();
        check_field("seconds", want.sec, seconds);
        check_field("minutes", want.min, minutes);
        check_field("hours", want.hour, hours);
        check_field("weekday", want.wday, weekday);
        check_field("day", want.day, day);
        check_field("month", want.month, month);
        check_field("year", want.year, year);
        check_field("adjust_ignored", want.ignored, adjust_ignored);
        check_field("field_error", want.ferr, field_error);
        n_checked++;
        if (want.ignored) n_skipped++;
        if (want.ferr) n_ferr++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words pending", cycle_count,
             predicted_clock_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_data     <= FLD_SEC;
    in_valid     <= 1'b0;
    mode         <= MODE_TICK;
    load_seconds <= '0;
    load_minutes <= '0;
    load_hours   <= '0;
    load_weekday <= '0;
    load_day     <= '0;
    load_month   <= '0;
    load_year    <= '0;
    reset_calendar();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_year_rollover();
    test_february();
    test_odd_months();
    test_load_extremes();
    test_invalid_field();
    test_adjust_alternation();
    test_random_phases();
    test_receiver_hold();
    wait_drained();

    $display("Checked %0d words: %0d ticks, %0d adjusts (%0d skipped, %0d bad field),",
             n_checked, n_tick, n_adjust, n_skipped, n_ferr);
    $display("%0d loads, %0d idle codes; all field selects, gaps, stalls and one hold",
             n_load, n_nop);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bcdc_pkg.sv
hw/rtl/bcdc_tick.sv
hw/rtl/bcdc_update.sv
hw/rtl/bcd_calendar_clock.sv
hw/rtl/bcdc_checker.sv
dv/tb_bcd_calendar_clock.sv
